[rtl/bptq_pkg.sv]
// bptq_pkg: shared constants, codes and types for the bounded priority task queue.
// No dependencies; all other rtl/ files but bptq_ram refer to it by scoped names.
`timescale 1ns / 1ps

package bptq_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PRIO_W      = 2;
    localparam int ENTRY_W     = TAG_BITS + PRIO_W;
    localparam int CAP_W       = 5;
    localparam int TOTAL_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_PRIO = 1'b1;

    localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;

    // register index, taken from paddr bit 2
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_POLICY   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_SETUP,
        S_SHIFT,
        S_SHIFT_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;     // input channel may take a transaction
        logic rd_issue;   // read slot idx, advance idx
        logic scan_use;   // returning read data feeds the best-entry compare
        logic shift_init; // idx starts just above the chosen slot
        logic shift_use;  // returning read data is written one slot lower
        logic commit;     // finish the item and load the output register
    } dp_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic deq_work;   // incoming transaction is a dequeue on a non-empty queue
        logic scan_last;
        logic shift_none;
        logic shift_last;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/bptq_req_if.sv]
// bptq_req_if: request channel (enqueue / dequeue transactions).
// Depends on bptq_pkg.
`timescale 1ns / 1ps

interface bptq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [bptq_pkg::TAG_BITS-1:0]    task_tag;
    logic [bptq_pkg::PRIO_W-1:0]      task_priority;

    modport source (output valid, opcode, task_tag, task_priority, input ready);
    modport sink   (input valid, opcode, task_tag, task_priority, output ready);
endinterface

[rtl/bptq_rsp_if.sv]
// bptq_rsp_if: result channel, one transaction per request.
// Depends on bptq_pkg.
`timescale 1ns / 1ps

interface bptq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [bptq_pkg::TAG_BITS-1:0]    out_tag;
    logic [bptq_pkg::PRIO_W-1:0]      out_priority;
    logic [bptq_pkg::CNT_W-1:0]       depth_now;
    logic [bptq_pkg::CNT_W-1:0]       high_watermark;
    logic [bptq_pkg::TOTAL_W-1:0]     submitted_count;
    logic [bptq_pkg::TOTAL_W-1:0]     rejected_count;

    modport source (output valid, status, out_tag, out_priority, depth_now,
                    high_watermark, submitted_count, rejected_count, input ready);
    modport sink   (input valid, status, out_tag, out_priority, depth_now,
                    high_watermark, submitted_count, rejected_count, output ready);
endinterface

[rtl/bptq_ram.sv]
// bptq_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module bptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bptq_ctrl.sv]
// bptq_ctrl: sequencer for accept, scan, shift-down and result commit.
// Depends on bptq_pkg; drives the datapath through dp_cmd_t only.
`timescale 1ns / 1ps

module bptq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bptq_pkg::dp_status_t  st,
    output bptq_pkg::dp_cmd_t     cmd
);

    bptq_pkg::state_t state_reg;
    bptq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bptq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bptq_pkg::S_IDLE:
            begin
                if (st.req_valid)
                begin
                    state_next = st.deq_work ? bptq_pkg::S_SCAN : bptq_pkg::S_DONE;
                end
            end
            bptq_pkg::S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = bptq_pkg::S_SCAN_WAIT;
                end
            end
            bptq_pkg::S_SCAN_WAIT:
            begin
                state_next = bptq_pkg::S_SHIFT_SETUP;
            end
            bptq_pkg::S_SHIFT_SETUP:
            begin
                state_next = st.shift_none ? bptq_pkg::S_DONE : bptq_pkg::S_SHIFT;
            end
            bptq_pkg::S_SHIFT:
            begin
                if (st.shift_last)
                begin
                    state_next = bptq_pkg::S_SHIFT_WAIT;
                end
            end
            bptq_pkg::S_SHIFT_WAIT:
            begin
                state_next = bptq_pkg::S_DONE;
            end
            bptq_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = bptq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bptq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            bptq_pkg::S_IDLE:
            begin
                cmd.accept = 1'b1;
            end
            bptq_pkg::S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                cmd.scan_use = 1'b1;
            end
            bptq_pkg::S_SCAN_WAIT:
            begin
                cmd.scan_use = 1'b1;
            end
            bptq_pkg::S_SHIFT_SETUP:
            begin
                cmd.shift_init = 1'b1;
            end
            bptq_pkg::S_SHIFT:
            begin
                cmd.rd_issue  = 1'b1;
                cmd.shift_use = 1'b1;
            end
            bptq_pkg::S_SHIFT_WAIT:
            begin
                cmd.shift_use = 1'b1;
            end
            bptq_pkg::S_DONE:
            begin
                cmd.commit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/bptq_datapath.sv]
// bptq_datapath: entry store, best-entry compare, shift-down, counters and result register.
// Depends on bptq_pkg, bptq_req_if, bptq_rsp_if and bptq_ram.
`timescale 1ns / 1ps

module bptq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    bptq_req_if.sink                      req,
    bptq_rsp_if.source                    rsp,
    input  logic [bptq_pkg::CAP_W-1:0]    capacity,
    input  logic                          policy,
    input  bptq_pkg::dp_cmd_t             cmd,
    output bptq_pkg::dp_status_t          st
);

    // captured request
    logic                              op_reg;
    logic [bptq_pkg::TAG_BITS-1:0]     tag_in_reg;
    logic [bptq_pkg::PRIO_W-1:0]       prio_in_reg;

    // queue bookkeeping
    logic [bptq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [bptq_pkg::CNT_W-1:0]        peak_reg, peak_next;
    logic [bptq_pkg::TOTAL_W-1:0]      sub_reg, sub_next;
    logic [bptq_pkg::TOTAL_W-1:0]      rej_reg, rej_next;

    // scan / shift walk
    logic [bptq_pkg::IDX_W-1:0]        idx_reg;
    logic                              rd_pend_reg;
    logic [bptq_pkg::IDX_W-1:0]        rd_addr_q_reg;
    logic [bptq_pkg::IDX_W-1:0]        best_idx_reg;
    logic [bptq_pkg::TAG_BITS-1:0]     best_tag_reg;
    logic [bptq_pkg::PRIO_W-1:0]       best_prio_reg;

    // result register
    logic                              out_valid_reg;
    bptq_pkg::status_t                 out_status_reg, out_status_next;
    logic [bptq_pkg::TAG_BITS-1:0]     out_tag_reg, out_tag_next;
    logic [bptq_pkg::PRIO_W-1:0]       out_prio_reg, out_prio_next;

    logic                              load;
    logic [bptq_pkg::CNT_W-1:0]        limit;
    logic [bptq_pkg::CNT_W-1:0]        cnt_m1;
    logic                              enq_full;
    logic                              enq_write;
    logic                              shift_write;
    logic                              ram_we;
    logic [bptq_pkg::IDX_W-1:0]        ram_waddr;
    logic [bptq_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [bptq_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [bptq_pkg::TAG_BITS-1:0]     rd_tag;
    logic [bptq_pkg::PRIO_W-1:0]       rd_prio;
    logic                              take_best;

    assign load      = cmd.accept & req.valid;
    assign req.ready = cmd.accept;

    always_comb
    begin
        if (capacity == '0 || int'(capacity) > bptq_pkg::STORE_DEPTH)
        begin
            limit = bptq_pkg::CNT_W'(bptq_pkg::STORE_DEPTH);
        end
        else
        begin
            limit = bptq_pkg::CNT_W'(capacity);
        end
    end

    assign cnt_m1   = count_reg - bptq_pkg::CNT_W'(1);
    assign enq_full = (count_reg >= limit);

    // status to the sequencer
    always_comb
    begin
        st.req_valid  = req.valid;
        st.deq_work   = (req.opcode == bptq_pkg::OP_DEQ) && (count_reg != '0);
        st.scan_last  = (policy == bptq_pkg::POLICY_PRIO) ?
                        (bptq_pkg::CNT_W'(idx_reg) == cnt_m1) : (idx_reg == '0);
        st.shift_none = (bptq_pkg::CNT_W'(best_idx_reg) + bptq_pkg::CNT_W'(1)) == count_reg;
        st.shift_last = (bptq_pkg::CNT_W'(idx_reg) + bptq_pkg::CNT_W'(1)) == count_reg;
        st.out_free   = !out_valid_reg || rsp.ready;
    end

    // entry store
    assign rd_tag      = ram_rdata[bptq_pkg::ENTRY_W-1:bptq_pkg::PRIO_W];
    assign rd_prio     = ram_rdata[bptq_pkg::PRIO_W-1:0];
    assign shift_write = cmd.shift_use & rd_pend_reg;
    assign enq_write   = cmd.commit & (op_reg == bptq_pkg::OP_ENQ) & !enq_full;
    assign ram_we      = shift_write | enq_write;

    always_comb
    begin
        if (shift_write)
        begin
            ram_waddr = rd_addr_q_reg - bptq_pkg::IDX_W'(1);
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_waddr = count_reg[bptq_pkg::IDX_W-1:0];
            ram_wdata = {tag_in_reg, prio_in_reg};
        end
    end

    bptq_ram #(
        .WIDTH (bptq_pkg::ENTRY_W),
        .DEPTH (bptq_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // first slot always taken; later ones only on strictly higher priority
    assign take_best = cmd.scan_use & rd_pend_reg &
                       ((rd_addr_q_reg == '0) || (rd_prio > best_prio_reg));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg      <= req.opcode;
            tag_in_reg  <= req.task_tag;
            prio_in_reg <= (req.task_priority > bptq_pkg::PRIO_HIGH) ?
                           bptq_pkg::PRIO_LOW : req.task_priority;
        end
        if (take_best)
        begin
            best_idx_reg  <= rd_addr_q_reg;
            best_tag_reg  <= rd_tag;
            best_prio_reg <= rd_prio;
        end
        rd_addr_q_reg <= idx_reg;
        if (cmd.commit)
        begin
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_prio_reg   <= out_prio_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            peak_reg      <= '0;
            sub_reg       <= '0;
            rej_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.shift_init)
            begin
                idx_reg <= best_idx_reg + bptq_pkg::IDX_W'(1);
            end
            else if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + bptq_pkg::IDX_W'(1);
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                peak_reg  <= peak_next;
                sub_reg   <= sub_next;
                rej_reg   <= rej_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // end-of-item update
    always_comb
    begin
        count_next      = count_reg;
        peak_next       = peak_reg;
        sub_next        = sub_reg;
        rej_next        = rej_reg;
        out_status_next = bptq_pkg::STATUS_OK;
        out_tag_next    = '0;
        out_prio_next   = '0;
        if (op_reg == bptq_pkg::OP_ENQ)
        begin
            if (enq_full)
            begin
                rej_next        = rej_reg + bptq_pkg::TOTAL_W'(1);
                out_status_next = bptq_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + bptq_pkg::CNT_W'(1);
                sub_next   = sub_reg + bptq_pkg::TOTAL_W'(1);
                if (count_next > peak_reg)
                begin
                    peak_next = count_next;
                end
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                out_status_next = bptq_pkg::STATUS_EMPTY;
            end
            else
            begin
                count_next    = cnt_m1;
                out_tag_next  = best_tag_reg;
                out_prio_next = best_prio_reg;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.out_tag         = out_tag_reg;
    assign rsp.out_priority    = out_prio_reg;
    assign rsp.depth_now       = count_reg;
    assign rsp.high_watermark  = peak_reg;
    assign rsp.submitted_count = sub_reg;
    assign rsp.rejected_count  = rej_reg;

endmodule

[rtl/bounded_priority_task_queue_top.sv]
// Bounded task queue with FIFO or priority service: top level, config registers.
// Depends on bptq_pkg, bptq_req_if, bptq_rsp_if, bptq_ctrl and bptq_datapath.
//
// Usage:
//   req carries one transaction per item: opcode 0 enqueues task_tag/task_priority,
//   opcode 1 dequeues. rsp returns exactly one transaction per request with status,
//   the dequeued tag and priority, current depth, high watermark and the two totals.
//   One item is in flight at a time; req.ready is high only while the block is idle.
//   Enqueue, or dequeue on an empty queue: committed with no scan of the store.
//   Dequeue: the entry store has a single read port; the priority scan reads every
//   held entry once (one slot in FIFO mode), then the younger entries are read and
//   rewritten one slot lower. req.ready returns in the same cycle that the result
//   turns valid.
//   The result sits in an output register; while rsp.ready is low the next request
//   may be taken and worked through, but it holds before commit and no further
//   request is accepted.
//   APB: capacity register at 0x0, service policy at 0x4; write only while idle.
//   Reset clears the queue, counters and watermark; capacity 0, policy priority.
`timescale 1ns / 1ps

module bounded_priority_task_queue_top (
    input  logic                            clk,
    input  logic                            rst_n,
    bptq_req_if.sink                        req,
    bptq_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bptq_pkg::PADDR_W-1:0]    paddr,
    input  logic [bptq_pkg::PDATA_W-1:0]    pwdata,
    output logic [bptq_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [bptq_pkg::CAP_W-1:0] capacity_reg;
    logic                       policy_reg;
    logic                       cfg_write;
    bptq_pkg::dp_cmd_t          cmd;
    bptq_pkg::dp_status_t       st;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
            policy_reg   <= bptq_pkg::POLICY_PRIO;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                bptq_pkg::REG_CAPACITY: capacity_reg <= pwdata[bptq_pkg::CAP_W-1:0];
                bptq_pkg::REG_POLICY:   policy_reg   <= pwdata[0];
                default:                policy_reg   <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            bptq_pkg::REG_CAPACITY: prdata = bptq_pkg::PDATA_W'(capacity_reg);
            bptq_pkg::REG_POLICY:   prdata = bptq_pkg::PDATA_W'(policy_reg);
            default:                prdata = '0;
        endcase
    end

    bptq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    bptq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .capacity (capacity_reg),
        .policy   (policy_reg),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

[tb/bptq_tb_pkg.sv]
// bptq_tb_pkg: result record and scoreboard class for the task queue testbench.
// Depends on bptq_pkg; the scoreboard carries its own copy of queue state and config.
`timescale 1ns / 1ps

package bptq_tb_pkg;

    import bptq_pkg::*;

    // priority code 3 is not a real level; the block stores it as low
    localparam logic [PRIO_W-1:0] PRIO_RESERVED = 2'd3;

    typedef struct {
        logic [1:0]          status;
        logic [TAG_BITS-1:0] tag;
        logic [PRIO_W-1:0]   prio;
        logic [CNT_W-1:0]    depth;
        logic [CNT_W-1:0]    peak;
        logic [TOTAL_W-1:0]  submitted;
        logic [TOTAL_W-1:0]  rejected;
    } result_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [PRIO_W-1:0]   prio;
    } task_entry_t;

    class task_queue_scoreboard;

        task_entry_t        held[$];      // slot order is age order
        result_t            expected[$];
        int unsigned        capacity;
        logic               policy;
        logic [CNT_W-1:0]   peak;
        logic [TOTAL_W-1:0] submitted;
        logic [TOTAL_W-1:0] refused;
        int unsigned        errors;

        function new();
            capacity  = 0;
            policy    = POLICY_PRIO;
            peak      = '0;
            submitted = '0;
            refused   = '0;
            errors    = 0;
        endfunction

        function void set_register(logic reg_index, int unsigned value);
            if (reg_index == REG_CAPACITY)
                capacity = value & ((1 << CAP_W) - 1);
            else
                policy = value[0];
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(logic opcode, logic [TAG_BITS-1:0] tag,
                                   logic [PRIO_W-1:0] prio);
            result_t     r;
            task_entry_t e;
            int unsigned limit;
            int          pick;
            r.status = STATUS_OK;
            r.tag    = '0;
            r.prio   = '0;
            e.tag    = tag;
            e.prio   = (prio > PRIO_HIGH) ? PRIO_LOW : prio;
            limit    = (capacity == 0 || capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
            if (opcode == OP_ENQ)
            begin
                if (held.size() >= limit)
                begin
                    refused++;
                    r.status = STATUS_FULL;
                end
                else
                begin
                    held.insert(held.size(), e);
                    submitted++;
                    if (held.size() > peak)
                        peak = CNT_W'(held.size());
                end
            end
            else if (held.size() == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                pick = 0;
                // strict compare keeps the oldest entry on a tie
                if (policy == POLICY_PRIO)
                    for (int i = 1; i < held.size(); i++)
                        if (held[i].prio > held[pick].prio)
                            pick = i;
                r.tag  = held[pick].tag;
                r.prio = held[pick].prio;
                held.delete(pick);
            end
            r.depth     = CNT_W'(held.size());
            r.peak      = peak;
            r.submitted = submitted;
            r.rejected  = refused;
            expected.insert(expected.size(), r);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want_v, got_v));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding: status %0d tag 0x%0h",
                                          got.status, got.tag));
                return;
            end
            want = expected[0];
            expected.delete(0);
            compare_field("status", want.status, got.status);
            compare_field("out_tag", want.tag, got.tag);
            compare_field("out_priority", want.prio, got.prio);
            compare_field("depth_now", want.depth, got.depth);
            compare_field("high_watermark", want.peak, got.peak);
            compare_field("submitted_count", want.submitted, got.submitted);
            compare_field("rejected_count", want.rejected, got.rejected);
        endtask

    endclass

endpackage

[tb/bounded_priority_task_queue_top_tb.sv]
// bounded_priority_task_queue_top_tb: directed and random enqueue/dequeue traffic
// under several capacity/policy settings and idle patterns. Depends on bptq_pkg,
// bptq_req_if, bptq_rsp_if, bptq_tb_pkg and the queue top level.
`timescale 1ns / 1ps

module bounded_priority_task_queue_top_tb;

    import bptq_pkg::*;
    import bptq_tb_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int ITEMS_PER_RUN = 105;
    localparam int PHASES        = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bptq_req_if req_ch ();
    bptq_rsp_if rsp_ch ();

    task_queue_scoreboard sb = new();

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int          quiet_cycles  = 0;
    result_t     seen;

    int unsigned phase_cap [PHASES] = '{4, 0, 16, 1, 31, 7, 20, 2};
    logic        phase_pol [PHASES] = '{POLICY_PRIO, POLICY_FIFO, POLICY_PRIO, POLICY_FIFO,
                                        POLICY_PRIO, POLICY_FIFO, POLICY_FIFO, POLICY_PRIO};

    bounded_priority_task_queue_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // result side: check each accepted transaction, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            seen.status    = rsp_ch.status;
            seen.tag       = rsp_ch.out_tag;
            seen.prio      = rsp_ch.out_priority;
            seen.depth     = rsp_ch.depth_now;
            seen.peak      = rsp_ch.high_watermark;
            seen.submitted = rsp_ch.submitted_count;
            seen.rejected  = rsp_ch.rejected_count;
            sb.check_result(seen);
        end
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_register(logic reg_index, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(reg_index, value);
    endtask

    // valid stays up from one transaction to the next unless an idle cycle is drawn
    task automatic send_item(logic op, logic [TAG_BITS-1:0] tag, logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.task_tag      <= tag;
        req_ch.task_priority <= prio;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(op, tag, prio);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(OP_DEQ, '0, PRIO_LOW);          // empty queue
        send_item(OP_ENQ, '1, PRIO_HIGH);
        send_item(OP_ENQ, '0, PRIO_RESERVED);     // stored as low
        send_item(OP_ENQ, 16'h1234, PRIO_NORMAL);
        send_item(OP_ENQ, 16'h8001, PRIO_HIGH);   // ties with the older high entry
        repeat (4)
            send_item(OP_DEQ, 16'hFFFF, PRIO_RESERVED);
        send_item(OP_DEQ, '0, PRIO_LOW);
        // fill the whole store, then one more is refused
        for (int i = 0; i <= STORE_DEPTH; i++)
            send_item(OP_ENQ, TAG_BITS'($urandom), PRIO_W'(i % 3));
    endtask

    task automatic run_random(int unsigned count);
        int unsigned         enq_pct;
        logic                op;
        logic [TAG_BITS-1:0] tag;
        logic [PRIO_W-1:0]   prio;
        enq_pct = 50;
        for (int unsigned n = 0; n < count; n++)
        begin
            // bursts that lean toward filling or draining the queue
            if (n % 16 == 0)
                case ($urandom_range(2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            case ($urandom_range(9))
                0: tag = '0;
                1: tag = '1;
                default: tag = TAG_BITS'($urandom);
            endcase
            prio = ($urandom_range(9) == 0) ? PRIO_RESERVED : PRIO_W'($urandom_range(PRIO_HIGH));
            send_item(op, tag, prio);
            if ($urandom_range(59) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_ENQ;
        req_ch.task_tag      <= '0;
        req_ch.task_priority <= PRIO_LOW;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_results();

        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_CAPACITY, phase_cap[p]);
            write_register(REG_POLICY, phase_pol[p]);
            case (p % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 46;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 46;
                end
                default:
                begin
                    src_idle_pct  = 27;
                    snk_stall_pct = 27;
                end
            endcase
            run_random(ITEMS_PER_RUN);
            wait_for_results();
        end

        repeat (40)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
